// ===== hdl/svpwm_mm_pkg.sv =====
// shared types, constants and formats of the min/max injection pwm block
package svpwm_mm_pkg;

    localparam int DUTY_FRAC_BITS = 15;
    localparam int QUO_W          = DUTY_FRAC_BITS + 1;
    localparam int DIV_STAGES     = QUO_W;
    localparam int P_W            = 35;
    localparam int DEN_W          = 34;
    localparam int REM_W          = 35;

    localparam logic signed [17:0] SQRT3_HALF_Q16 = 18'sd56756;
    localparam logic [15:0]        BUS_MIN_RAW    = 16'd256;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_OVERMOD = 2'd1;
    localparam logic [1:0] STATUS_BAD_BUS = 2'd2;

    typedef struct packed {
        logic signed [15:0] v_alpha;
        logic signed [15:0] v_beta;
        logic [15:0]        v_bus;
    } in_t;

    typedef struct packed {
        logic [15:0] duty_a;
        logic [15:0] duty_b;
        logic [15:0] duty_c;
        logic [1:0]  status;
    } out_t;

    typedef struct packed {
        logic [2:0]             neg;
        logic [2:0][REM_W-1:0]  rem;
        logic [2:0][QUO_W-1:0]  quo;
        logic [DEN_W-1:0]       den;
        logic                   ovm;
        logic                   bad;
    } div_t;

endpackage

// ===== hdl/svpwm_minmax_injection.sv =====
// Pipeline: 4 front stages + DUTY_FRAC_BITS+1 division stages + 1 output stage.
// Throughput: one request per cycle when not stalled; each division stage retires one
// quotient bit for all three phases; stages with no request fill while the output stalls.
// Reset: rst_n clears all valid bits asynchronously; data registers are not reset.
// The block holds no state between requests.
module svpwm_minmax_injection
    import svpwm_mm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic sample_valid,
    output logic sample_stall,
    input  in_t  sample,
    output logic result_valid,
    input  logic result_stall,
    output out_t result
);

    div_t stage_data  [DIV_STAGES+1];
    logic stage_valid [DIV_STAGES+1];
    logic stage_stall [DIV_STAGES+1];

    // phase values, min/max and divisor
    svpwm_mm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_valid),
        .in_stall  (sample_stall),
        .in_data   (sample),
        .out_valid (stage_valid[0]),
        .out_stall (stage_stall[0]),
        .out_data  (stage_data[0])
    );

    // division chain, one quotient bit per stage
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        svpwm_mm_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[k]),
            .in_stall  (stage_stall[k]),
            .in_data   (stage_data[k]),
            .out_valid (stage_valid[k+1]),
            .out_stall (stage_stall[k+1]),
            .out_data  (stage_data[k+1])
        );
    end

    // rounding and duty output
    svpwm_mm_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid[DIV_STAGES]),
        .in_stall  (stage_stall[DIV_STAGES]),
        .in_data   (stage_data[DIV_STAGES]),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_data  (result)
    );

endmodule

// ===== hdl/svpwm_mm_front.sv =====
// front end: clarke products, phase values, min/max, numerators and divisor
module svpwm_mm_front
    import svpwm_mm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_stall,
    output div_t out_data
);

    logic [3:0] valid_reg;
    logic [3:0] adv;

    // per-stage advance, bubbles collapse
    assign adv[3]    = !valid_reg[3] || !out_stall;
    assign adv[2]    = !valid_reg[2] || adv[3];
    assign adv[1]    = !valid_reg[1] || adv[2];
    assign adv[0]    = !valid_reg[0] || adv[1];
    assign in_stall  = !adv[0];
    assign out_valid = valid_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0]) valid_reg[0] <= in_valid;
            if (adv[1]) valid_reg[1] <= valid_reg[0];
            if (adv[2]) valid_reg[2] <= valid_reg[1];
            if (adv[3]) valid_reg[3] <= valid_reg[2];
        end
    end

    // stage a: alpha scaling and the sqrt3/2 product
    logic signed [31:0] u_reg;
    logic signed [33:0] w_reg;
    logic signed [33:0] w_next;
    logic [15:0]        bus_a_reg;

    assign w_next = SQRT3_HALF_Q16 * in_data.v_beta;

    always_ff @(posedge clk)
    begin
        if (adv[0] && in_valid)
        begin
            u_reg     <= 32'(in_data.v_alpha) <<< 15;
            w_reg     <= w_next;
            bus_a_reg <= in_data.v_bus;
        end
    end

    // stage b: inverse clarke phase values
    logic signed [P_W-1:0] pa_reg, pb_reg, pc_reg;
    logic [15:0]           bus_b_reg;
    logic signed [P_W-1:0] u_ext, w_ext;

    assign u_ext = P_W'(u_reg);
    assign w_ext = P_W'(w_reg);

    always_ff @(posedge clk)
    begin
        if (adv[1] && valid_reg[0])
        begin
            pa_reg    <= u_ext <<< 1;
            pb_reg    <= w_ext - u_ext;
            pc_reg    <= -u_ext - w_ext;
            bus_b_reg <= bus_a_reg;
        end
    end

    // stage c: max and min of the three phases
    logic signed [P_W-1:0] qa_reg, qb_reg, qc_reg, max_reg, min_reg;
    logic signed [P_W-1:0] max_ab, min_ab;
    logic [15:0]           bus_c_reg;

    assign max_ab = (pb_reg > pa_reg) ? pb_reg : pa_reg;
    assign min_ab = (pb_reg < pa_reg) ? pb_reg : pa_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2] && valid_reg[1])
        begin
            qa_reg    <= pa_reg;
            qb_reg    <= pb_reg;
            qc_reg    <= pc_reg;
            max_reg   <= (pc_reg > max_ab) ? pc_reg : max_ab;
            min_reg   <= (pc_reg < min_ab) ? pc_reg : min_ab;
            bus_c_reg <= bus_b_reg;
        end
    end

    // stage d: span, divisor choice, bus check and centered numerators
    logic [DEN_W-1:0]      span;
    logic [DEN_W-1:0]      bus_den;
    logic                  ovm;
    logic signed [P_W:0]   num [3];
    logic signed [P_W:0]   mid;
    logic signed [P_W-1:0] q [3];
    div_t                  d_next;
    div_t                  d_reg;

    assign span    = DEN_W'(max_reg - min_reg);
    assign bus_den = DEN_W'({bus_c_reg, 16'b0});
    assign ovm     = span > bus_den;
    assign mid     = (P_W+1)'(max_reg) + (P_W+1)'(min_reg);
    assign q[0]    = qa_reg;
    assign q[1]    = qb_reg;
    assign q[2]    = qc_reg;

    always_comb
    begin
        d_next     = '0;
        d_next.den = ovm ? span : bus_den;
        d_next.ovm = ovm;
        d_next.bad = bus_c_reg < BUS_MIN_RAW;
        for (int i = 0; i < 3; i++)
        begin
            num[i]        = ((P_W+1)'(q[i]) <<< 1) - mid;
            d_next.neg[i] = num[i][P_W];
            d_next.rem[i] = num[i][P_W] ? REM_W'(-num[i]) : REM_W'(num[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3] && valid_reg[2])
        begin
            d_reg <= d_next;
        end
    end

    assign out_data = d_reg;

endmodule

// ===== hdl/svpwm_mm_div_stage.sv =====
// one restoring division step for the three phase quotients
module svpwm_mm_div_stage
    import svpwm_mm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  div_t in_data,
    output logic out_valid,
    input  logic out_stall,
    output div_t out_data
);

    logic valid_reg;
    logic adv;
    div_t d_next;
    div_t d_reg;

    assign adv       = !valid_reg || !out_stall;
    assign in_stall  = !adv;
    assign out_valid = valid_reg;

    // compare, subtract, shift in the quotient bit
    always_comb
    begin
        logic             ge;
        logic [REM_W-1:0] r1;
        d_next = in_data;
        for (int i = 0; i < 3; i++)
        begin
            ge = in_data.rem[i] >= REM_W'(in_data.den);
            r1 = ge ? in_data.rem[i] - REM_W'(in_data.den) : in_data.rem[i];
            d_next.rem[i] = r1 << 1;
            d_next.quo[i] = {in_data.quo[i][QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            d_reg <= d_next;
        end
    end

    assign out_data = d_reg;

endmodule

// ===== hdl/svpwm_mm_out.sv =====
// output stage: rounding, centering at one half, clamp and status
module svpwm_mm_out
    import svpwm_mm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  div_t in_data,
    output logic out_valid,
    input  logic out_stall,
    output out_t out_data
);

    localparam int                HALF_INT = 1 << (DUTY_FRAC_BITS - 1);
    localparam int                ONE_INT  = 1 << DUTY_FRAC_BITS;
    localparam logic signed [QUO_W+1:0] HALF = (QUO_W+2)'(HALF_INT);
    localparam logic signed [QUO_W+1:0] ONE  = (QUO_W+2)'(ONE_INT);

    logic valid_reg;
    logic adv;
    out_t o_next;
    out_t o_reg;
    logic [15:0] duty [3];

    assign adv       = !valid_reg || !out_stall;
    assign in_stall  = !adv;
    assign out_valid = valid_reg;

    // round half away from zero, then clamp to [0, 1]
    always_comb
    begin
        logic [QUO_W:0]          qr;
        logic signed [QUO_W+1:0] d;
        for (int i = 0; i < 3; i++)
        begin
            qr = ((QUO_W+1)'(in_data.quo[i]) + (QUO_W+1)'(1)) >> 1;
            d  = in_data.neg[i] ? HALF - (QUO_W+2)'(qr) : HALF + (QUO_W+2)'(qr);
            if (d < 0)
                d = '0;
            else if (d > ONE)
                d = ONE;
            duty[i] = in_data.bad ? 16'(HALF_INT) : 16'(d);
        end
        o_next.duty_a = duty[0];
        o_next.duty_b = duty[1];
        o_next.duty_c = duty[2];
        if (in_data.bad)
            o_next.status = STATUS_BAD_BUS;
        else if (in_data.ovm)
            o_next.status = STATUS_OVERMOD;
        else
            o_next.status = STATUS_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            o_reg <= o_next;
        end
    end

    assign out_data = o_reg;

endmodule
